// ===== hdl/rme_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ZYX Euler angle block: widths, CORDIC angle table, helpers.
// No dependencies.
package rme_pkg;
    localparam int MATRIX_FRAC_BITS_DEF = 14;
    localparam int ANGLE_FRAC_BITS_DEF  = 13;
    localparam int IN_W    = 16;
    localparam int STEPS   = 31;
    localparam int XW      = 64;
    localparam int ZW      = 34;
    localparam int SQ_W    = 31;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XW-1:0] Q30_ONE     = 64'sd1073741824;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        case (i)
            0: atan_entry = 34'sd843314857;
            1: atan_entry = 34'sd497837829;
            2: atan_entry = 34'sd263043837;
            3: atan_entry = 34'sd133525159;
            4: atan_entry = 34'sd67021687;
            5: atan_entry = 34'sd33543516;
            6: atan_entry = 34'sd16775851;
            7: atan_entry = 34'sd8388437;
            8: atan_entry = 34'sd4194283;
            9: atan_entry = 34'sd2097149;
            10: atan_entry = 34'sd1048576;
            default: atan_entry = ZW'(64'sd1 <<< (30 - i));
        endcase
    endfunction

    // Prepare atan2 start: reflect x<0 into right half plane, scale by 2^30.
    function automatic t_vec atan_start(input logic signed [31:0] y,
                                        input logic signed [31:0] x);
        t_vec v;
        logic signed [XW-1:0] xx;
        logic signed [XW-1:0] yy;
        xx = XW'(x);
        yy = XW'(y);
        v.z = '0;
        if (x < 0) begin
            v.z = (y < 0) ? -PI_Q30 : PI_Q30;
            xx = -xx;
            yy = -yy;
        end
        v.x = xx <<< 30;
        v.y = yy <<< 30;
        atan_start = v;
    endfunction
endpackage

// ===== hdl/rme_cell.sv =====
`timescale 1ns / 1ps
// One CORDIC vectoring cell for three lanes plus a side payload.
// Depends on rme_pkg.
module rme_cell #(
    parameter int STEP = 0,
    parameter int PW   = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  rme_pkg::t_vec     i_v [3],
    input  logic [PW-1:0]     i_p,
    output rme_pkg::t_vec     o_v [3],
    output logic [PW-1:0]     o_p
);
    import rme_pkg::*;
    t_vec n_v [3];
    t_vec r_v [3];
    logic [PW-1:0] r_p;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_v[k] = i_v[k];
            if (i_v[k].y >= 0) begin
                n_v[k].x = i_v[k].x + (i_v[k].y >>> STEP);
                n_v[k].y = i_v[k].y - (i_v[k].x >>> STEP);
                n_v[k].z = i_v[k].z + atan_entry(STEP);
            end else begin
                n_v[k].x = i_v[k].x - (i_v[k].y >>> STEP);
                n_v[k].y = i_v[k].y + (i_v[k].x >>> STEP);
                n_v[k].z = i_v[k].z - atan_entry(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_p <= i_p;
        end
    end
    assign o_v = r_v;
    assign o_p = r_p;
endmodule

// ===== hdl/rme_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One bit of a restoring integer square root, for cos(theta) from r20.
// Depends on rme_pkg.
module rme_sqrt_cell #(
    parameter int BIT = 0,
    parameter int PW  = 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [60:0]               i_rem,
    input  logic [rme_pkg::SQ_W-1:0]  i_root,
    input  logic [PW-1:0]             i_p,
    output logic [60:0]               o_rem,
    output logic [rme_pkg::SQ_W-1:0]  o_root,
    output logic [PW-1:0]             o_p
);
    import rme_pkg::*;
    logic [62:0] w_trial;
    logic [60:0] r_rem;
    logic [SQ_W-1:0] r_root;
    logic [PW-1:0] r_p;

    // trial = (2*root + 2^bit) * 2^bit  computed in 63 bits
    assign w_trial = ((63'(i_root) << (BIT + 1)) | (63'(1) << (2 * BIT)));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (63'(i_rem) >= w_trial) begin
                r_rem  <= 61'(63'(i_rem) - w_trial);
                r_root <= i_root | (SQ_W'(1) << BIT);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
            r_p <= i_p;
        end
    end
    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_p = r_p;
endmodule

// ===== hdl/rotation_matrix_to_euler_angles_top.sv =====
`timescale 1ns / 1ps
// Top level of the ZYX Euler angle block: saturation, sqrt chain, CORDIC chain,
// rounding and output register. Depends on rme_pkg, rme_sqrt_cell, rme_cell.
//
// Takes a rotation matrix per cycle when not stalled; returns psi, theta, phi.
// Stages: input register, 31 sqrt cells, 31 CORDIC cells, round and output
// register. The whole chain advances only when the output register is free or
// being taken, so throughput is one transaction per cycle with no bubbles.
// Entries saturate to +-1.0 first; r20 = +-1.0 exactly is gimbal lock (phi = 0,
// theta = -+pi/2, psi from r01/r02 instead of r21/r22). atan2(0,0) gives 0.
module rotation_matrix_to_euler_angles_top #(
    parameter int MATRIX_FRAC_BITS = rme_pkg::MATRIX_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS  = rme_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // r00, r01, r02, r10, r20, r21, r22 (16 bits each, lowest first)
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_psi[15:0], pitch_theta[30:16], yaw_phi[46:31], zero pad to 48
    output logic [47:0]  m_axis_tdata
);
    import rme_pkg::*;

    localparam int LAT = 1 + 2 * STEPS;
    localparam int RS  = 30 - ANGLE_FRAC_BITS;
    // payload through the sqrt chain: r20, psi y, psi x, r10, r00, gimbal code
    localparam int PW  = 5 * 32 + 2;
    localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic r_ov;
    logic [47:0] r_od;

    // chain moves when output is free or draining
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;

    function automatic logic signed [31:0] sat(input logic [15:0] raw);
        logic signed [31:0] v;
        logic signed [31:0] one;
        v = 32'(signed'(raw));
        one = 32'sd1 <<< MATRIX_FRAC_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        sat = v <<< (30 - MATRIX_FRAC_BITS);
    endfunction

    // stage 0: saturate
    logic signed [31:0] w_r [7];
    always_comb for (int k = 0; k < 7; k++) w_r[k] = sat(s_axis_tdata[16*k +: 16]);

    // psi operands: r21/r22 normally, -r01/-r02 at r20 = +1, r01/r02 at r20 = -1
    logic signed [31:0] w_psi_y, w_psi_x;
    always_comb begin
        if (w_r[4] == ONE_Q30) begin
            w_psi_y = -w_r[1];
            w_psi_x = -w_r[2];
        end else if (w_r[4] == -ONE_Q30) begin
            w_psi_y = w_r[1];
            w_psi_x = w_r[2];
        end else begin
            w_psi_y = w_r[5];
            w_psi_x = w_r[6];
        end
    end

    // r20 squared, full 64-bit product
    logic signed [63:0] w_sq;
    assign w_sq = w_r[4] * w_r[4];

    logic [60:0] r_rem0;
    logic [PW-1:0] r_p0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem0 <= 61'((64'd1 << 60) - w_sq);
            r_p0 <= {(w_r[4] == ONE_Q30), (w_r[4] == -ONE_Q30),
                     w_r[0], w_r[3], w_psi_x, w_psi_y, w_r[4]};
        end
    end
    // r_p0 layout: [31:0] r20 [63:32] psi y [95:64] psi x [127:96] r10
    // [159:128] r00 [160] r20==-1 [161] r20==+1

    logic [60:0] w_rem [STEPS+1];
    logic [SQ_W-1:0] w_root [STEPS+1];
    logic [PW-1:0] w_sp [STEPS+1];
    assign w_rem[0] = r_rem0;
    assign w_root[0] = '0;
    assign w_sp[0] = r_p0;

    for (genvar g = 0; g < STEPS; g++) begin : g_sq
        rme_sqrt_cell #(.BIT(STEPS - 1 - g), .PW(PW)) u_sq (
            .i_clk(i_clk), .i_en(w_en),
            .i_rem(w_rem[g]), .i_root(w_root[g]), .i_p(w_sp[g]),
            .o_rem(w_rem[g+1]), .o_root(w_root[g+1]), .o_p(w_sp[g+1]));
    end

    // select atan2 operands per lane
    logic signed [31:0] s20, s21, s22, s10, s00, s01n, s02n, sc;
    logic lk_p, lk_n;
    t_vec w_v0 [3];
    logic [1:0] w_cp0;
    always_comb begin
        s20 = w_sp[STEPS][31:0];
        s21 = w_sp[STEPS][63:32];
        s22 = w_sp[STEPS][95:64];
        s10 = w_sp[STEPS][127:96];
        s00 = w_sp[STEPS][159:128];
        lk_n = w_sp[STEPS][160];
        lk_p = w_sp[STEPS][161];
        sc = 32'(w_root[STEPS]);
        // psi lane operands were already swapped for gimbal lock at the input
        s01n = s21;
        s02n = s22;
        w_v0[0] = atan_start(s20, sc);
        w_v0[1] = atan_start(s01n, s02n);
        w_v0[2] = atan_start(s10, s00);
        if (s10 == 0 && s00 == 0) w_v0[2] = '0;
        if (s01n == 0 && s02n == 0) w_v0[1] = '0;
        w_cp0 = {lk_p, lk_n};
    end

    t_vec w_v [STEPS+1][3];
    logic [3*2+1:0] w_cp [STEPS+1];
    // side payload: lock flags and zero-vector flags for the psi and phi lanes
    assign w_v[0] = w_v0;
    assign w_cp[0] = {w_cp0, 1'b0, (s01n == 0 && s02n == 0), (s10 == 0 && s00 == 0),
                      3'b0};

    for (genvar g = 0; g < STEPS; g++) begin : g_cd
        rme_cell #(.STEP(g), .PW(8)) u_cd (
            .i_clk(i_clk), .i_en(w_en), .i_v(w_v[g]), .i_p(w_cp[g]),
            .o_v(w_v[g+1]), .o_p(w_cp[g+1]));
    end

    function automatic logic signed [ZW-1:0] rnd(input logic signed [ZW-1:0] z,
                                                 input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] t;
        t = z;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        rnd = (t + (ZW'(1) <<< (RS - 1))) >>> RS;
    endfunction

    logic signed [ZW-1:0] a_psi, a_th, a_phi, z_psi, z_th, z_phi;
    always_comb begin
        z_th  = w_v[STEPS][0].z;
        z_psi = w_cp[STEPS][4] ? '0 : w_v[STEPS][1].z;
        z_phi = w_cp[STEPS][3] ? '0 : w_v[STEPS][2].z;
        if (w_cp[STEPS][7]) begin
            z_th = HALF_PI_Q30;
            z_phi = '0;
        end else if (w_cp[STEPS][6]) begin
            z_th = -HALF_PI_Q30;
            z_phi = '0;
        end
        a_psi = rnd(z_psi, PI_Q30);
        a_th  = rnd(-z_th, HALF_PI_Q30);
        a_phi = rnd(z_phi, PI_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
            r_ov <= r_vld[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_od <= {1'b0, a_phi[15:0], a_th[14:0], a_psi[15:0]};
    end
endmodule

// ===== hdl/rme_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Euler angle block, bound to the top level.
// Depends on nothing beyond the top level's ports.
module rme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[47])
        else $error("pad bit set");
endmodule

bind rotation_matrix_to_euler_angles_top rme_checker u_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_euler_angles_top: random and directed matrices,
// predicted with a fixed-point CORDIC model and checked in order. Depends on rme_pkg.
module testbench;
    import rme_pkg::*;

    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 70;

    localparam longint PI_Q   = 64'sd3373259426;
    localparam longint HPI_Q  = 64'sd1686629713;
    localparam longint ONE_Q  = 64'sd1073741824;

    typedef struct packed {
        logic signed [15:0] yaw_phi;
        logic signed [14:0] pitch_theta;
        logic signed [15:0] roll_psi;
    } t_angles;

    // ---------------- predictor ----------------
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(int i);
        longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i <= 10) return tbl[i];
        return longint'(1) << (30 - i);
    endfunction

    function automatic longint vector_atan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y < 0) ? -PI_Q : PI_Q;
            x = -x;
            y = -y;
        end
        x = x * ONE_Q;
        y = y * ONE_Q;
        for (int i = 0; i < 31; i++) begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            if (y >= 0) begin
                x += dy; y -= dx; z += cordic_angle(i);
            end else begin
                x -= dy; y += dx; z -= cordic_angle(i);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint saturate_entry(logic signed [15:0] v);
        longint t;
        t = v;
        if (t > 16384) t = 16384;
        if (t < -16384) t = -16384;
        return t * (longint'(1) << 16);
    endfunction

    function automatic longint round_angle(longint z, longint lim);
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return (z + (longint'(1) << 16)) >>> 17;
    endfunction

    function automatic t_angles predict_angles(logic [111:0] m);
        longint e[7];
        longint psi, theta, phi, c;
        t_angles a;
        for (int k = 0; k < 7; k++) e[k] = saturate_entry(m[16*k +: 16]);
        // e: r00 r01 r02 r10 r20 r21 r22
        if (e[4] == ONE_Q) begin
            phi = 0; theta = -HPI_Q; psi = vector_atan2(-e[1], -e[2]);
        end else if (e[4] == -ONE_Q) begin
            phi = 0; theta = HPI_Q; psi = vector_atan2(e[1], e[2]);
        end else begin
            c = longint'(int_sqrt((64'd1 << 60) - longint'(e[4] * e[4])));
            theta = -vector_atan2(e[4], c);
            psi = vector_atan2(e[5], e[6]);
            phi = vector_atan2(e[3], e[0]);
        end
        a.roll_psi    = 16'(round_angle(psi, PI_Q));
        a.pitch_theta = 15'(round_angle(theta, HPI_Q));
        a.yaw_phi     = 16'(round_angle(phi, PI_Q));
        return a;
    endfunction

    // ---------------- scoreboard ----------------
    class angle_scoreboard;
        t_angles pending[$];
        int errors = 0;
        int checked = 0;

        function void note_matrix(logic [111:0] m);
            pending.push_back(predict_angles(m));
        endfunction

        function void check_angles(logic [47:0] d);
            t_angles got, exp_a;
            got = d[46:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            exp_a = pending.pop_front();
            checked++;
            if (got.roll_psi !== exp_a.roll_psi) begin
                $display("%0t: psi exp %0d got %0d", $time, exp_a.roll_psi, got.roll_psi);
                errors++;
            end
            if (got.pitch_theta !== exp_a.pitch_theta) begin
                $display("%0t: theta exp %0d got %0d", $time, exp_a.pitch_theta,
                         got.pitch_theta);
                errors++;
            end
            if (got.yaw_phi !== exp_a.yaw_phi) begin
                $display("%0t: phi exp %0d got %0d", $time, exp_a.yaw_phi, got.yaw_phi);
                errors++;
            end
            if (d[47] !== 1'b0) begin
                $display("%0t: pad exp 0 got %b", $time, d[47]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [47:0]  m_axis_tdata;

    angle_scoreboard sb = new();
    int  idle_cycles = 0;
    int  sent = 0;
    bit  long_hold = 0;   // receiver long hold-off request

    always #5 i_clk = ~i_clk;

    rotation_matrix_to_euler_angles_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // sample transactions on both sides
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_matrix(s_axis_tdata);
                sent++;
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_angles(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired");
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, stretches with no stall, one long hold-off
    initial begin : receiver
        int mode, n;
        mode = 0;
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 40);
            repeat (n) begin
                @(posedge i_clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic logic [15:0] random_entry();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);                 // full range, may saturate
            3: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    function automatic logic [111:0] random_matrix();
        logic [111:0] m;
        for (int k = 0; k < 7; k++) m[16*k +: 16] = random_entry();
        return m;
    endfunction

    // offer one matrix and hold it until the block takes it
    task automatic send_matrix(logic [111:0] m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [111:0] pack7(int a, int b, int c, int d, int e, int f, int g);
        return {16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    initial begin : stimulus
        logic [111:0] dir[$];
        int burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zeros, gimbal lock both ways, saturation, extremes
        dir.push_back(pack7(16384, 0, 0, 0, 0, 0, 16384));
        dir.push_back(pack7(0, 0, 0, 0, 0, 0, 0));
        dir.push_back(pack7(0, 5000, -7000, 0, 16384, 0, 0));
        dir.push_back(pack7(0, 5000, -7000, 0, -16384, 0, 0));
        dir.push_back(pack7(0, 0, 0, 0, 16384, 0, 0));
        dir.push_back(pack7(0, 0, 0, 0, -16384, 0, 0));
        dir.push_back(pack7(0, 0, 0, 0, 32767, 0, 0));
        dir.push_back(pack7(0, 0, 0, 0, -32768, 0, 0));
        dir.push_back(pack7(-32768, 32767, -32768, 32767, 16383, 32767, -32768));
        dir.push_back(pack7(-16384, 0, 0, 0, 0, 0, -16384));
        dir.push_back(pack7(-16384, 0, 0, 1, -16383, -1, -16384));
        dir.push_back(pack7(-16384, 0, 0, -1, 0, 1, -16384));
        dir.push_back(pack7(0, 0, 0, 16384, 0, -16384, 0));
        dir.push_back(pack7(0, 0, 0, -16384, 1, 16384, 0));
        dir.push_back(pack7(-1, -1, -1, -1, -1, -1, -1));
        dir.push_back(pack7(65535, 0, 0, 0, 0, 0, 0));
        dir.push_back(pack7(11585, 3, -3, 11585, 11585, -11585, 11585));
        dir.push_back(pack7(16384, 16384, 16384, 16384, 16383, 16384, 16384));
        foreach (dir[k]) send_matrix(dir[k]);
        wait_drained();

        // fill the pipe against a long receiver hold-off
        long_hold = 1;
        for (int k = 0; k < 200; k++) send_matrix(random_matrix());

        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 60);
            repeat (burst) send_matrix(random_matrix());
            case ($urandom_range(0, 9)) inside
                0: wait_drained();
                [1:3]: pause_sender($urandom_range(1, 12));
                default: ;
            endcase
        end
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);

        $display("Covered %0d matrices incl. gimbal lock, saturation and zero vectors,",
                 sent);
        $display("with random stalls on both sides; %0d results compared.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
